[sv/pvkf_pkg.sv]
// ----------------------------------------------------------------------------
// pvkf_pkg
// Shared types and constants for the position/velocity tracking filter.
// ----------------------------------------------------------------------------
`default_nettype none
package pvkf_pkg;

    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned RegWidth        = 31;

    localparam logic [30:0] ProcNoiseReset = 31'd66;
    localparam logic [30:0] MeasNoiseReset = 31'd2621;
    localparam logic [30:0] InitVarReset   = 31'd65536000;

    typedef enum logic [1:0] {
        REG_PROC_NOISE = 2'd0,
        REG_MEAS_NOISE = 2'd1,
        REG_INIT_VAR   = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [31:0]        time_stamp;
        logic signed [31:0] measurement;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] est_position;
        logic signed [31:0] est_velocity;
        logic signed [31:0] pred_position;
        logic signed [31:0] pred_velocity;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg_item;

endpackage
`default_nettype wire

[sv/position_velocity_kalman_filter_top.sv]
// ----------------------------------------------------------------------------
// position_velocity_kalman_filter_top
// Two-state constant-velocity tracking filter with one shared multiplier,
// one shared adder with saturation and a restoring divider, driven by a
// microcoded sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  input     in         i_in_valid/o_in_ready  t_in_item
//  result    out        o_out_valid/i_out_ready t_out_item
//  config    in         i_cfg_valid/o_cfg_ready t_cfg_item
//
//  A priming sample is taken without leaving idle and gives no result.
//  Any other sample runs 25 sequencer steps, 23 of them single operations
//  and two of them the gain divisions, and the input stays not ready from
//  acceptance until the result is loaded; the serial divider takes most of
//  this time. The result waits in an output register. An untaken result
//  stalls the following sample after its last step, until it is taken.
//  Reset restores register defaults and clears the filter state.
// ----------------------------------------------------------------------------
`default_nettype none
module position_velocity_kalman_filter_top #(
    parameter int unsigned FRAC_BITS = pvkf_pkg::FracBitsDefault
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire pvkf_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output pvkf_pkg::t_out_item      o_out_data,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire pvkf_pkg::t_cfg_item i_cfg_data
);
    import pvkf_pkg::*;

    localparam int unsigned DivBits = 32 + FRAC_BITS;
    localparam int unsigned CntW    = $clog2(DivBits + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_OUT  = 6'b010000,
        ST_NEXT = 6'b100000
    } t_state;

    // Operand/destination codes for the microprogram.
    typedef enum logic [3:0] {
        V_ZERO, V_DT, V_XP0, V_XP1, V_P00, V_P01, V_P11, V_Y, V_S,
        V_K0, V_K1, V_T, V_Z, V_Q, V_R, V_NONE
    } t_var;

    typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} t_op;

    typedef struct packed {
        t_op  op;
        t_var a;
        t_var b;
        t_var c;
        t_var d;
        t_var dst;
    } t_uop;

    localparam int unsigned NumSteps = 25;
    localparam int unsigned PcW = 5;

    function automatic t_uop uop(input logic [PcW-1:0] pc);
        t_uop u;
        u = '{OP_ADD, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_NONE};
        case (pc)
            5'd0:  u = '{OP_MUL, V_DT,  V_XP1,  V_ZERO, V_ZERO, V_T};
            5'd1:  u = '{OP_ADD, V_XP0, V_T,    V_ZERO, V_ZERO, V_XP0};
            5'd2:  u = '{OP_MUL, V_DT,  V_P11,  V_ZERO, V_ZERO, V_T};
            5'd3:  u = '{OP_ADD, V_P01, V_T,    V_ZERO, V_ZERO, V_Y};
            5'd4:  u = '{OP_MUL, V_DT,  V_P01,  V_ZERO, V_ZERO, V_S};
            5'd5:  u = '{OP_MUL, V_DT,  V_Y,    V_ZERO, V_ZERO, V_T};
            5'd6:  u = '{OP_ADD, V_P00, V_S,    V_T,    V_Q,    V_P00};
            5'd7:  u = '{OP_ADD, V_Y,   V_ZERO, V_ZERO, V_ZERO, V_P01};
            5'd8:  u = '{OP_ADD, V_P11, V_Q,    V_ZERO, V_ZERO, V_P11};
            5'd9:  u = '{OP_SUB, V_Z,   V_XP0,  V_ZERO, V_ZERO, V_Y};
            5'd10: u = '{OP_ADD, V_P00, V_R,    V_ZERO, V_ZERO, V_S};
            5'd11: u = '{OP_DIV, V_P00, V_S,    V_ZERO, V_ZERO, V_K0};
            5'd12: u = '{OP_DIV, V_P01, V_S,    V_ZERO, V_ZERO, V_K1};
            5'd13: u = '{OP_MUL, V_K0,  V_Y,    V_ZERO, V_ZERO, V_T};
            5'd14: u = '{OP_ADD, V_XP0, V_T,    V_ZERO, V_ZERO, V_XP0};
            5'd15: u = '{OP_MUL, V_K1,  V_Y,    V_ZERO, V_ZERO, V_T};
            5'd16: u = '{OP_ADD, V_XP1, V_T,    V_ZERO, V_ZERO, V_XP1};
            5'd17: u = '{OP_MUL, V_K1,  V_P01,  V_ZERO, V_ZERO, V_T};
            5'd18: u = '{OP_SUB, V_P11, V_T,    V_ZERO, V_ZERO, V_P11};
            5'd19: u = '{OP_MUL, V_K0,  V_P01,  V_ZERO, V_ZERO, V_T};
            5'd20: u = '{OP_SUB, V_P01, V_T,    V_ZERO, V_ZERO, V_P01};
            5'd21: u = '{OP_MUL, V_K0,  V_P00,  V_ZERO, V_ZERO, V_T};
            5'd22: u = '{OP_SUB, V_P00, V_T,    V_ZERO, V_ZERO, V_P00};
            5'd23: u = '{OP_MUL, V_DT,  V_XP1,  V_ZERO, V_ZERO, V_T};
            5'd24: u = '{OP_ADD, V_XP0, V_T,    V_ZERO, V_ZERO, V_Y};
            default: u = '{OP_ADD, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_NONE};
        endcase
        return u;
    endfunction

    localparam logic [PcW-1:0] LastPc = PcW'(NumSteps - 1);

    t_state r_state, n_state;
    logic [PcW-1:0] r_pc;
    logic [30:0] r_q, r_r, r_iv;
    logic signed [31:0] r_xp0, r_xp1, r_p00, r_p01, r_p11, r_y, r_s, r_k0, r_k1, r_t, r_z;
    logic [31:0] r_dt, r_last;
    logic r_primed, r_sat;
    t_out_item r_out;
    logic r_out_valid;

    // Divider state.
    logic [CntW-1:0] r_cnt;
    logic [DivBits-1:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [DivBits-1:0] r_num;
    logic r_neg;

    t_uop u;
    logic signed [32:0] a_v, b_v, c_v, d_v;
    logic signed [65:0] prod;
    logic signed [65:0] prod_r;
    logic signed [65:0] sh;
    logic signed [35:0] sum;
    logic signed [31:0] res;
    logic res_sat;

    function automatic logic signed [32:0] sel(input t_var v,
        input logic [31:0] dt, input logic signed [31:0] xp0, xp1, p00, p01, p11,
        y, s, k0, k1, t, z, input logic [30:0] q, rr);
        logic signed [32:0] o;
        o = '0;
        case (v)
            V_DT:  o = {1'b0, dt};
            V_XP0: o = 33'(xp0);
            V_XP1: o = 33'(xp1);
            V_P00: o = 33'(p00);
            V_P01: o = 33'(p01);
            V_P11: o = 33'(p11);
            V_Y:   o = 33'(y);
            V_S:   o = 33'(s);
            V_K0:  o = 33'(k0);
            V_K1:  o = 33'(k1);
            V_T:   o = 33'(t);
            V_Z:   o = 33'(z);
            V_Q:   o = {2'b00, q};
            V_R:   o = {2'b00, rr};
            default: o = '0;
        endcase
        return o;
    endfunction

    always_comb begin
        u   = uop(r_pc);
        a_v = sel(u.a, r_dt, r_xp0, r_xp1, r_p00, r_p01, r_p11, r_y, r_s, r_k0, r_k1,
                  r_t, r_z, r_q, r_r);
        b_v = sel(u.b, r_dt, r_xp0, r_xp1, r_p00, r_p01, r_p11, r_y, r_s, r_k0, r_k1,
                  r_t, r_z, r_q, r_r);
        c_v = sel(u.c, r_dt, r_xp0, r_xp1, r_p00, r_p01, r_p11, r_y, r_s, r_k0, r_k1,
                  r_t, r_z, r_q, r_r);
        d_v = sel(u.d, r_dt, r_xp0, r_xp1, r_p00, r_p01, r_p11, r_y, r_s, r_k0, r_k1,
                  r_t, r_z, r_q, r_r);
        prod = 66'(a_v) * 66'(b_v);
        sh   = (prod_r + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (u.op == OP_SUB) begin
            sum = 36'(a_v) - 36'(b_v);
        end else begin
            sum = 36'(a_v) + 36'(b_v) + 36'(c_v) + 36'(d_v);
        end
        res = '0;
        res_sat = 1'b0;
        unique case (r_state)
            ST_MUL: begin
                if (sh > 66'sd2147483647) begin
                    res = 32'sh7fffffff; res_sat = 1'b1;
                end else if (sh < -66'sd2147483648) begin
                    res = 32'sh80000000; res_sat = 1'b1;
                end else begin
                    res = sh[31:0];
                end
            end
            ST_DIV: begin
                if (r_quo > DivBits'(32'h7fffffff) && !r_neg) begin
                    res = 32'sh7fffffff; res_sat = 1'b1;
                end else if (r_quo > DivBits'(32'h80000000) && r_neg) begin
                    res = 32'sh80000000; res_sat = 1'b1;
                end else if (r_neg) begin
                    res = -$signed(r_quo[31:0]);
                end else begin
                    res = r_quo[31:0];
                end
            end
            default: begin
                if (sum > 36'sd2147483647) begin
                    res = 32'sh7fffffff; res_sat = 1'b1;
                end else if (sum < -36'sd2147483648) begin
                    res = 32'sh80000000; res_sat = 1'b1;
                end else begin
                    res = sum[31:0];
                end
            end
        endcase
    end

    // Sequencer: IDLE -> NEXT (loads product register) -> MUL, ADD or DIV for gains -> NEXT or OUT.
    logic in_fire;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic step_done;
    logic out_load;
    logic [DivBits-1:0] trial_num;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem[31:0], r_num[DivBits-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        trial_num = '0;
        trial_num[DivBits-1:FRAC_BITS] = a_v[32] ? 32'(-a_v) : a_v[31:0];
        out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
        step_done = 1'b0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire && !(i_in_data.restart || !r_primed)) begin
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                unique case (u.op)
                    OP_MUL:  n_state = ST_MUL;
                    OP_DIV:  n_state = ST_DIV;
                    default: n_state = ST_ADD;
                endcase
            end
            ST_MUL: step_done = 1'b1;
            ST_ADD: step_done = 1'b1;
            ST_DIV: step_done = (r_cnt == '0);
            ST_OUT: if (out_load) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (step_done) begin
            n_state = (r_pc == LastPc) ? ST_OUT : ST_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_q         <= ProcNoiseReset;
            r_r         <= MeasNoiseReset;
            r_iv        <= InitVarReset;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_xp0 <= '0; r_xp1 <= '0; r_p00 <= '0; r_p01 <= '0; r_p11 <= '0;
            r_last <= '0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_data.index)
                    REG_PROC_NOISE: r_q  <= i_cfg_data.data[30:0];
                    REG_MEAS_NOISE: r_r  <= i_cfg_data.data[30:0];
                    REG_INIT_VAR:   r_iv <= i_cfg_data.data[30:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_last <= i_in_data.time_stamp;
                r_z    <= i_in_data.measurement;
                r_dt   <= i_in_data.time_stamp - r_last;
                r_pc   <= '0;
                r_sat  <= 1'b0;
                if (i_in_data.restart || !r_primed) begin
                    r_xp0    <= i_in_data.measurement;
                    r_xp1    <= '0;
                    r_p00    <= 32'({1'b0, r_iv});
                    r_p01    <= '0;
                    r_p11    <= 32'({1'b0, r_iv});
                    r_primed <= 1'b1;
                end
            end
            if (r_state == ST_NEXT) begin
                prod_r <= prod;
                if (u.op == OP_DIV) begin
                    r_cnt <= CntW'(DivBits);
                    r_num <= trial_num;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_den <= r_s;
                    r_neg <= a_v[32];
                end
            end
            if (r_state == ST_DIV && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= {r_num[DivBits-2:0], 1'b0};
                if (!rem_sub[32]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[DivBits-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[DivBits-2:0], 1'b0};
                end
            end
            if (step_done) begin
                r_pc <= r_pc + 1'b1;
                if (!(u.op == OP_DIV && r_s <= 0)) begin
                    r_sat <= r_sat | res_sat;
                end
                unique case (u.dst)
                    V_XP0: r_xp0 <= res;
                    V_XP1: r_xp1 <= res;
                    V_P00: r_p00 <= res;
                    V_P01: r_p01 <= res;
                    V_P11: r_p11 <= res;
                    V_Y:   r_y   <= res;
                    V_S:   r_s   <= res;
                    V_K0:  r_k0  <= (r_s > 0) ? res : 32'sd0;
                    V_K1:  r_k1  <= (r_s > 0) ? res : 32'sd0;
                    V_T:   r_t   <= res;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out.est_position  <= r_xp0;
                r_out.est_velocity  <= r_xp1;
                r_out.pred_position <= r_y;
                r_out.pred_velocity <= r_xp1;
                r_out.saturated     <= r_sat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_out_valid)
        else $error("result not presented after sequence end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CntW'(DivBits)))
        else $error("divider count out of range");

endmodule
`default_nettype wire

[bench/pvkf_checker.sv]
// ----------------------------------------------------------------------------
// pvkf_checker
// Watches the sample, result and register channels of the tracking filter,
// keeps its own fixed-point copy of the filter state and settings, predicts
// each result and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module pvkf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  pvkf_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pvkf_pkg::t_out_item i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  pvkf_pkg::t_cfg_item i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pvkf_pkg::*;

    localparam int unsigned Frac = FracBitsDefault;

    logic [30:0] proc_noise, meas_noise, init_var;
    int          pos_est, vel_est, cov_pp, cov_pv, cov_vv;
    logic [31:0] last_stamp;
    bit          primed;
    bit          clamped;
    t_out_item   estimates_due[$];

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) begin
            clamped = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clamped = 1'b1;
            return 32'h80000000;
        end
        return int'(v);
    endfunction

    function automatic int fx_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (Frac - 1));
        return sat32(p >>> Frac);
    endfunction

    function automatic int fx_div(int num, int den);
        longint n;
        n = longint'(num) * (64'sd1 <<< Frac);
        return sat32(n / longint'(den));
    endfunction

    task automatic track_sample(t_in_item s);
        logic [31:0] diff;
        longint      dt;
        int          xp0, xp1, pp00, pp01, pp11, y, sv, k0, k1;
        t_out_item   r;
        if (s.restart || !primed) begin
            pos_est    = s.measurement;
            vel_est    = 0;
            cov_pp     = int'({1'b0, init_var});
            cov_pv     = 0;
            cov_vv     = int'({1'b0, init_var});
            last_stamp = s.time_stamp;
            primed     = 1'b1;
            return;
        end
        clamped = 1'b0;
        diff    = s.time_stamp - last_stamp;
        dt      = longint'({32'd0, diff});
        xp0  = sat32(longint'(pos_est) + fx_mul(dt, vel_est));
        xp1  = vel_est;
        pp01 = sat32(longint'(cov_pv) + fx_mul(dt, cov_vv));
        pp00 = sat32(longint'(cov_pp) + fx_mul(dt, cov_pv) + fx_mul(dt, pp01)
                     + longint'({33'd0, proc_noise}));
        pp11 = sat32(longint'(cov_vv) + longint'({33'd0, proc_noise}));
        y    = sat32(longint'(s.measurement) - longint'(xp0));
        sv   = sat32(longint'(pp00) + longint'({33'd0, meas_noise}));
        if (sv > 0) begin
            k0 = fx_div(pp00, sv);
            k1 = fx_div(pp01, sv);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        pos_est    = sat32(longint'(xp0) + fx_mul(k0, y));
        vel_est    = sat32(longint'(xp1) + fx_mul(k1, y));
        cov_pp     = sat32(longint'(pp00) - fx_mul(k0, pp00));
        cov_pv     = sat32(longint'(pp01) - fx_mul(k0, pp01));
        cov_vv     = sat32(longint'(pp11) - fx_mul(k1, pp01));
        last_stamp = s.time_stamp;
        r.est_position  = pos_est;
        r.est_velocity  = vel_est;
        r.pred_position = sat32(longint'(pos_est) + fx_mul(dt, vel_est));
        r.pred_velocity = vel_est;
        r.saturated     = clamped;
        estimates_due = {estimates_due, r};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_errors++;
        end
    endtask

    assign o_pending = estimates_due.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            proc_noise = ProcNoiseReset;
            meas_noise = MeasNoiseReset;
            init_var   = InitVarReset;
            pos_est    = 0;
            vel_est    = 0;
            cov_pp     = 0;
            cov_pv     = 0;
            cov_vv     = 0;
            last_stamp = '0;
            primed     = 1'b0;
            estimates_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_PROC_NOISE: proc_noise = i_cfg_data.data[30:0];
                    REG_MEAS_NOISE: meas_noise = i_cfg_data.data[30:0];
                    REG_INIT_VAR:   init_var   = i_cfg_data.data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                track_sample(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (estimates_due.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, i_out_data);
                    o_errors++;
                end else begin
                    want = estimates_due.pop_front();
                    check_field("est_position", want.est_position, i_out_data.est_position);
                    check_field("est_velocity", want.est_velocity, i_out_data.est_velocity);
                    check_field("pred_position", want.pred_position,
                                i_out_data.pred_position);
                    check_field("pred_velocity", want.pred_velocity,
                                i_out_data.pred_velocity);
                    check_field("saturated", {31'd0, want.saturated},
                                {31'd0, i_out_data.saturated});
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the tracking filter with directed corner samples and then with
// mostly well-formed random tracks under several register settings, with
// random idling on both channels; pvkf_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pvkf_pkg::*;

    localparam logic [1:0] RegUnused   = 2'd3;
    localparam int         RandomItems = 1730;
    localparam int         PhaseCount  = 5;
    localparam int         StallLimit  = 20000;
    localparam int         SettleTime  = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    t_cfg_item cfg_data = '0;
    int        errors, pending;
    int        in_idle = 24, out_idle = 61;
    int        quiet_cycles = 0;
    logic [31:0] track_stamp = '0;
    logic [31:0] track_pos = '0;

    always #5 i_clk = ~i_clk;

    position_velocity_kalman_filter_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    pvkf_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= out_idle);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("position_velocity_kalman_filter_top test failed");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [31:0] stamp, logic [31:0] meas, logic restart);
        while ($urandom_range(99) < in_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{time_stamp: stamp, measurement: meas, restart: restart};
        @(negedge i_clk);
        while (!in_ready) @(negedge i_clk);
        @(posedge i_clk);
        track_stamp = stamp;
        track_pos   = meas;
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= '{index: index, data: value};
        @(negedge i_clk);
        while (!cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleTime) @(posedge i_clk);
    endtask

    task automatic random_sample();
        int          pick;
        logic [31:0] jitter;
        pick = $urandom_range(99);
        if (pick < 85) begin
            jitter = $urandom_range(8192) - 4096;
            send_sample(track_stamp + $urandom_range(131072, 256), track_pos + jitter,
                        ($urandom_range(99) < 2));
        end else if (pick < 92) begin
            send_sample($urandom(), $urandom(), 1'($urandom_range(1)));
        end else begin
            send_sample(track_stamp + $urandom_range(65536),
                        track_pos + ($urandom_range(1) ? 32'h0100_0000 : 32'hff00_0000),
                        1'b0);
        end
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0002_0000, 32'h7fff_ffff, 1'b0);
        send_sample(32'h0003_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_sample(32'h0000_8000, 32'h1234_5678, 1'b1);
        send_sample(32'h0000_9000, 32'h1234_6000, 1'b0);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0100, 32'h0000_0000, 1'b1);
        send_sample(32'h8000_0200, 32'h0000_0400, 1'b0);
        send_sample(32'h8001_0200, 32'h0000_0800, 1'b0);
        settle();

        n = 0;
        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_PROC_NOISE, 32'h8000_0000 | $urandom_range(65536));
                    write_reg(REG_MEAS_NOISE, 32'h8000_0000 | $urandom_range(1 << 20));
                    write_reg(REG_INIT_VAR, 32'h8000_0000 | $urandom());
                end
                2: begin
                    write_reg(REG_PROC_NOISE, 32'd0);
                    write_reg(REG_MEAS_NOISE, 32'd0);
                    write_reg(REG_INIT_VAR, 32'd0);
                end
                3: begin
                    write_reg(REG_PROC_NOISE, 32'h7fff_ffff);
                    write_reg(REG_MEAS_NOISE, 32'h7fff_ffff);
                    write_reg(REG_INIT_VAR, 32'h7fff_ffff);
                end
                4: begin
                    write_reg(RegUnused, $urandom());
                    write_reg(REG_PROC_NOISE, 32'd66);
                    write_reg(REG_MEAS_NOISE, 32'd2621);
                    write_reg(REG_INIT_VAR, 32'd65536000);
                end
                default: ;
            endcase
            send_sample(track_stamp + 32'h100, track_pos, 1'b1);
            for (int k = 0; k < RandomItems / PhaseCount; k++) begin
                if (n < RandomItems / 3) begin
                    in_idle  = 24;
                    out_idle = 61;
                end else if (n < 2 * RandomItems / 3) begin
                    in_idle  = 61;
                    out_idle = 24;
                end else begin
                    in_idle  = 0;
                    out_idle = 0;
                end
                random_sample();
                n++;
            end
            settle();
        end

        if (errors == 0) begin
            $display("position_velocity_kalman_filter_top test passed");
        end else begin
            $display("position_velocity_kalman_filter_top test failed");
        end
        $finish;
    end

endmodule

[position_velocity_kalman_filter_top.f]
sv/pvkf_pkg.sv
sv/position_velocity_kalman_filter_top.sv
bench/pvkf_checker.sv
bench/testbench.sv
